// ===== src/nfc_response_deframer_with_ack_assert.svh =====
// Assertion macros shared by the deframer checker.
`ifndef NFC_RESPONSE_DEFRAMER_WITH_ACK_ASSERT_SVH
`define NFC_RESPONSE_DEFRAMER_WITH_ACK_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define NRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define NRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nrd_pkg.sv =====
// Types and constants shared by the response deframer modules.
package nrd_pkg;

    localparam logic [7:0] READY_BYTE = 8'h01;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] FF_BYTE    = 8'hFF;
    localparam logic [7:0] RESP_ID    = 8'hD5;
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'hFF;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_OK   = 2'd2,
        KIND_FAIL = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT      = 3'd0,
        PH_LEN       = 3'd1,
        PH_AFTER_LEN = 3'd2,
        PH_IDENT     = 3'd3,
        PH_BODY      = 3'd4,
        PH_WAIT      = 3'd5,
        PH_DONE      = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       block_start;
        logic       block_end;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] payload_count;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic      have;
        t_out_item item;
    } t_parse_res;

endpackage

// ===== src/nrd_in_reg.sv =====
// Input register stage of the response deframer.
module nrd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  nrd_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    input  logic              i_advance,
    output logic              o_valid,
    output nrd_pkg::t_in_item o_item
);

    logic              r_valid;
    nrd_pkg::t_in_item r_item;
    logic              load;

    // The stage takes a new item when it is empty or its item moves on.
    assign load       = !r_valid || i_advance;
    assign o_in_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_item <= i_in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/nrd_parser.sv =====
// Frame parser state machine: consumes one byte per fire and forms its result.
module nrd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  nrd_pkg::t_in_item   i_item,
    input  logic [7:0]          i_max_payload,
    output nrd_pkg::t_parse_res o_res
);

    nrd_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_prog, n_prog;
    logic [7:0]      r_len, n_len;
    logic [7:0]      r_pos, n_pos;
    logic [7:0]      r_cnt, n_cnt;
    logic            r_at_head;

    nrd_pkg::t_phase e_phase, sw_phase;
    logic [1:0]      e_prog;
    logic [7:0]      e_len, e_pos, e_cnt, b;
    logic            head, skip, is_end, body_last, deliver;

    assign b      = i_item.rx_byte;
    assign is_end = i_item.block_end;
    assign head   = i_item.block_start || r_at_head;
    assign skip   = head && (b == nrd_pkg::READY_BYTE);

    // A block head clears all frame state before the byte is looked at.
    assign e_phase = head ? nrd_pkg::PH_HUNT : r_phase;
    assign e_prog  = head ? 2'd0 : r_prog;
    assign e_len   = head ? 8'd0 : r_len;
    assign e_pos   = head ? 8'd0 : r_pos;
    assign e_cnt   = head ? 8'd0 : r_cnt;

    assign body_last = ({1'b0, e_pos} + 9'd1) >= {1'b0, e_len};
    assign deliver   = !is_end && (e_cnt < i_max_payload);

    // Next state.
    always_comb begin
        sw_phase = e_phase;
        n_prog   = e_prog;
        n_len    = e_len;
        n_pos    = e_pos;
        n_cnt    = e_cnt;
        if (!skip) begin
            unique case (e_phase)
                nrd_pkg::PH_HUNT: begin
                    if (b == nrd_pkg::FF_BYTE && e_prog == 2'd2) begin
                        sw_phase = nrd_pkg::PH_LEN;
                        n_prog   = 2'd0;
                    end else if (b == nrd_pkg::ZERO_BYTE) begin
                        if (e_prog < 2'd2) begin
                            n_prog = e_prog + 2'd1;
                        end
                    end else begin
                        n_prog = 2'd0;
                    end
                end
                nrd_pkg::PH_LEN: begin
                    n_len    = b;
                    sw_phase = nrd_pkg::PH_AFTER_LEN;
                end
                nrd_pkg::PH_AFTER_LEN: begin
                    if (e_len == 8'd0 && b != nrd_pkg::FF_BYTE) begin
                        sw_phase = nrd_pkg::PH_DONE;
                    end else begin
                        sw_phase = nrd_pkg::PH_IDENT;
                    end
                end
                nrd_pkg::PH_IDENT: begin
                    if (e_len == 8'd0) begin
                        sw_phase = (b == nrd_pkg::ZERO_BYTE) ? nrd_pkg::PH_WAIT
                                                              : nrd_pkg::PH_DONE;
                    end else if (b != nrd_pkg::RESP_ID) begin
                        sw_phase = nrd_pkg::PH_DONE;
                    end else begin
                        n_pos    = 8'd0;
                        sw_phase = nrd_pkg::PH_BODY;
                    end
                end
                nrd_pkg::PH_BODY: begin
                    if (body_last) begin
                        sw_phase = nrd_pkg::PH_DONE;
                    end else begin
                        n_pos = e_pos + 8'd1;
                        if (deliver) begin
                            n_cnt = e_cnt + 8'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        // A block that ends in any phase up to the body, hunting included, ends with failure.
        if (is_end && sw_phase <= nrd_pkg::PH_BODY) begin
            n_phase = nrd_pkg::PH_DONE;
        end else begin
            n_phase = sw_phase;
        end
    end

    // Result of this byte.
    always_comb begin
        o_res.have               = 1'b0;
        o_res.item.kind          = nrd_pkg::KIND_DATA;
        o_res.item.data_byte     = 8'd0;
        if (!skip) begin
            unique case (e_phase)
                nrd_pkg::PH_AFTER_LEN: begin
                    if (e_len == 8'd0 && b != nrd_pkg::FF_BYTE) begin
                        o_res.have      = 1'b1;
                        o_res.item.kind = nrd_pkg::KIND_FAIL;
                    end
                end
                nrd_pkg::PH_IDENT: begin
                    if (e_len == 8'd0) begin
                        o_res.have      = 1'b1;
                        o_res.item.kind = (b == nrd_pkg::ZERO_BYTE) ? nrd_pkg::KIND_ACK
                                                                     : nrd_pkg::KIND_FAIL;
                    end else if (b != nrd_pkg::RESP_ID) begin
                        o_res.have      = 1'b1;
                        o_res.item.kind = nrd_pkg::KIND_FAIL;
                    end
                end
                nrd_pkg::PH_BODY: begin
                    if (body_last) begin
                        o_res.have      = 1'b1;
                        o_res.item.kind = nrd_pkg::KIND_OK;
                    end else if (deliver) begin
                        o_res.have           = 1'b1;
                        o_res.item.kind      = nrd_pkg::KIND_DATA;
                        o_res.item.data_byte = b;
                    end
                end
                default: begin
                end
            endcase
        end
        if (is_end && sw_phase <= nrd_pkg::PH_BODY) begin
            o_res.have           = 1'b1;
            o_res.item.kind      = nrd_pkg::KIND_FAIL;
            o_res.item.data_byte = 8'd0;
        end
        o_res.item.payload_count = (o_res.item.kind == nrd_pkg::KIND_ACK) ? 8'd0 : n_cnt;
        o_res.item.last = (o_res.item.kind == nrd_pkg::KIND_OK)
                       || (o_res.item.kind == nrd_pkg::KIND_FAIL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= nrd_pkg::PH_HUNT;
            r_prog    <= 2'd0;
            r_len     <= 8'd0;
            r_pos     <= 8'd0;
            r_cnt     <= 8'd0;
            r_at_head <= 1'b1;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_prog    <= n_prog;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_cnt     <= n_cnt;
            r_at_head <= is_end;
        end
    end

endmodule

// ===== src/nrd_out_reg.sv =====
// Result register stage of the response deframer.
module nrd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_valid,
    input  nrd_pkg::t_parse_res i_res,
    output logic                o_out_valid,
    output nrd_pkg::t_out_item  o_out_item
);

    logic               r_valid;
    nrd_pkg::t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid && i_res.have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid && i_res.have) begin
            r_item <= i_res.item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

// ===== src/nfc_response_deframer_with_ack.sv =====
// Top level of the reader-link response deframer.
//
// The input channel (i_in_valid, i_in_item, o_in_stall) carries one link byte per
// item, with flags that mark the first and last byte of a read block. The output
// channel (o_out_valid, o_out_item, i_out_stall) carries at most one result item
// per input item: a payload byte, an acknowledge, frame ok, or failure.
// The max_payload register is written through i_cfg_we / i_cfg_data and resets
// to 255; the user must write it only while the block is idle, since the block
// itself does not enforce this. An item accepted at a clock edge is held in the
// input register and parsed by the state machine there; its result, if any, is
// loaded into the result register when the pipeline next advances. One item is
// taken every cycle while the receiver does not stall; the parser state updates
// in a single pass, so nothing limits the rate below that.
// When the receiver stalls, the result register holds its item, the input
// register fills, and o_in_stall rises until the result is taken; no item is
// lost or repeated. Synchronous reset empties both registers, returns the parser
// to preamble hunting and treats the next byte as the head of a block.
module nfc_response_deframer_with_ack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  nrd_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output nrd_pkg::t_out_item o_out_item,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data
);

    logic                r_max_payload;
    logic [7:0]          r_max_payload_q;
    logic                advance;
    logic                stage_valid;
    logic                fire;
    nrd_pkg::t_in_item   stage_item;
    nrd_pkg::t_parse_res parse_res;

    // Configuration register; the one-bit flag only records that a write happened
    // since reset so that the reset value is held until then.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload   <= 1'b0;
            r_max_payload_q <= nrd_pkg::MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            r_max_payload   <= 1'b1;
            r_max_payload_q <= i_cfg_data;
        end
    end

    // The pipeline moves whenever the result register is empty or being taken.
    assign advance = !o_out_valid || !i_out_stall;
    assign fire    = stage_valid && advance;

    nrd_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_advance  (advance),
        .o_valid    (stage_valid),
        .o_item     (stage_item)
    );

    nrd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (stage_item),
        .i_max_payload (r_max_payload ? r_max_payload_q : nrd_pkg::MAX_PAYLOAD_RESET),
        .o_res         (parse_res)
    );

    nrd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_valid     (stage_valid),
        .i_res       (parse_res),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== src/nrd_checker.sv =====
// Port-level checker for the response deframer and its bind statement.
`include "nfc_response_deframer_with_ack_assert.svh"

module nrd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input nrd_pkg::t_out_item o_out_item,
    input logic               i_out_stall
);

    logic out_held;

    assign out_held = o_out_valid && i_out_stall;

    `NRD_ASSERT_NOW(a_data_only_on_payload, i_clk, i_rst_n, o_out_valid && (o_out_item.kind != nrd_pkg::KIND_DATA), o_out_item.data_byte == 8'd0, "data byte set on a non-payload result")
    `NRD_ASSERT_NOW(a_last_on_end_results, i_clk, i_rst_n, o_out_valid, o_out_item.last == ((o_out_item.kind == nrd_pkg::KIND_OK) || (o_out_item.kind == nrd_pkg::KIND_FAIL)), "last flag does not match result kind")
    `NRD_ASSERT_NOW(a_ack_count_zero, i_clk, i_rst_n, o_out_valid && (o_out_item.kind == nrd_pkg::KIND_ACK), o_out_item.payload_count == 8'd0, "acknowledge carries a payload count")
    `NRD_ASSERT_NEXT(a_stalled_result_holds, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_item), "stalled result changed")

endmodule

bind nfc_response_deframer_with_ack nrd_checker u_nrd_checker (.*);

// ===== tb/deframer_checker.sv =====
// Checker for the response deframer: predicts results from accepted link bytes and compares.
module deframer_checker
    import nrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_item,
    input  logic       i_in_stall,
    input  logic       i_out_valid,
    input  t_out_item  i_out_item,
    input  logic       i_out_stall,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output int         o_pending,
    output int         o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 30;

    // Private copy of the parser state and the payload limit register.
    t_phase     cur_phase;
    logic [1:0] zero_run;
    logic [7:0] frame_len;
    logic [7:0] body_pos;
    logic [7:0] sent_count;
    logic       head_pending;
    logic [7:0] payload_limit;

    t_out_item  predicted_events[$];
    int         mismatches = 0;
    int         result_no = 0;

    function automatic void restart_parse();
        cur_phase  = PH_HUNT;
        zero_run   = 2'd0;
        frame_len  = 8'd0;
        body_pos   = 8'd0;
        sent_count = 8'd0;
    endfunction

    // Advances the parser by one link byte; returns 1 when the byte yields a result.
    function automatic bit parse_link_byte(input t_in_item it, output t_out_item res);
        logic       skip;
        logic       have;
        t_kind      kind;
        logic [7:0] data;
        skip = 1'b0;
        have = 1'b0;
        kind = KIND_DATA;
        data = 8'h00;
        if (it.block_start || head_pending) begin
            restart_parse();
            skip = (it.rx_byte == READY_BYTE);
        end
        head_pending = it.block_end;
        if (!skip) begin
            case (cur_phase)
                PH_HUNT: begin
                    if (it.rx_byte == FF_BYTE && zero_run == 2'd2) begin
                        cur_phase = PH_LEN;
                        zero_run  = 2'd0;
                    end else if (it.rx_byte == ZERO_BYTE) begin
                        if (zero_run < 2'd2) zero_run = zero_run + 2'd1;
                    end else begin
                        zero_run = 2'd0;
                    end
                end
                PH_LEN: begin
                    frame_len = it.rx_byte;
                    cur_phase = PH_AFTER_LEN;
                end
                PH_AFTER_LEN: begin
                    if (frame_len == 8'd0 && it.rx_byte != FF_BYTE) begin
                        have = 1'b1;
                        kind = KIND_FAIL;
                        cur_phase = PH_DONE;
                    end else begin
                        cur_phase = PH_IDENT;
                    end
                end
                PH_IDENT: begin
                    if (frame_len == 8'd0) begin
                        have = 1'b1;
                        if (it.rx_byte == ZERO_BYTE) begin
                            kind = KIND_ACK;
                            cur_phase = PH_WAIT;
                        end else begin
                            kind = KIND_FAIL;
                            cur_phase = PH_DONE;
                        end
                    end else if (it.rx_byte != RESP_ID) begin
                        have = 1'b1;
                        kind = KIND_FAIL;
                        cur_phase = PH_DONE;
                    end else begin
                        body_pos  = 8'd0;
                        cur_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (int'(body_pos) + 1 >= int'(frame_len)) begin
                        have = 1'b1;
                        kind = KIND_OK;
                        cur_phase = PH_DONE;
                    end else begin
                        body_pos = body_pos + 8'd1;
                        // Bytes past the limit, or one that closes the block, are not delivered.
                        if (!it.block_end && sent_count < payload_limit) begin
                            sent_count = sent_count + 8'd1;
                            have = 1'b1;
                            kind = KIND_DATA;
                            data = it.rx_byte;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        // A block that closes before the frame or acknowledge is complete fails.
        if (it.block_end && cur_phase <= PH_BODY) begin
            have = 1'b1;
            kind = KIND_FAIL;
            data = 8'h00;
            cur_phase = PH_DONE;
        end
        res.kind          = kind;
        res.data_byte     = (kind == KIND_DATA) ? data : 8'h00;
        res.payload_count = (kind == KIND_ACK) ? 8'd0 : sent_count;
        res.last          = (kind == KIND_OK || kind == KIND_FAIL);
        return have;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item predicted;
        t_out_item want;
        if (!i_rst_n) begin
            payload_limit = MAX_PAYLOAD_RESET;
            restart_parse();
            head_pending = 1'b1;
            predicted_events.delete();
        end else begin
            if (i_cfg_we) payload_limit = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (predicted_events.size() == 0) begin
                    flag_mismatch($sformatf("result %0d: unexpected item, kind %0d data %02h",
                                            result_no, i_out_item.kind, i_out_item.data_byte));
                end else begin
                    want = predicted_events.pop_front();
                    if (i_out_item.kind !== want.kind)
                        flag_mismatch($sformatf("result %0d: kind %0d, expected %0d",
                                                result_no, i_out_item.kind, want.kind));
                    if (i_out_item.data_byte !== want.data_byte)
                        flag_mismatch($sformatf("result %0d: data_byte %02h, expected %02h",
                                                result_no, i_out_item.data_byte,
                                                want.data_byte));
                    if (i_out_item.payload_count !== want.payload_count)
                        flag_mismatch($sformatf("result %0d: payload_count %0d, expected %0d",
                                                result_no, i_out_item.payload_count,
                                                want.payload_count));
                    if (i_out_item.last !== want.last)
                        flag_mismatch($sformatf("result %0d: last %b, expected %b",
                                                result_no, i_out_item.last, want.last));
                end
                result_no++;
            end
            if (i_in_valid && !i_in_stall && parse_link_byte(i_in_item, predicted))
                predicted_events.push_back(predicted);
        end
        o_pending    <= predicted_events.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== tb/tb.sv =====
// Top of the response deframer testbench: clock, reset, stimulus, receiver and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nrd_pkg::*;

    // The run is bounded well above the slowest legal run: roughly 3500 link
    // bytes at worst, each behind a long sender gap and a long receiver stall,
    // plus the long receiver hold-off and the drains between phases.
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned LONG_HOLD    = 400;
    // The block passes each byte through its input register to its result register;
    // the extra settle time covers bytes still in flight that produce no result.
    localparam int unsigned SETTLE       = 6;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned PHASES       = 8;

    // Every block input holds a known value from time zero.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;
    logic       out_stall = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_data  = 8'h00;

    int         pending;
    int         fail_count;

    // The stimulus asks the receiver for one long hold-off; the receiver
    // marks it done so that it happens exactly once.
    bit         hold_req  = 1'b0;
    bit         hold_done = 1'b0;
    // Forces the next well-formed frame to the longest length.
    bit         force_long = 1'b0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;

    // The read block under construction, one item per link byte.
    t_in_item   blk[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nfc_response_deframer_with_ack DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    deframer_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_item    (in_item),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_item   (out_item),
        .i_out_stall  (out_stall),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (fail_count)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Idle lengths shared by both sides: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, stretches with no stall at all, and the one
    // long hold-off during which the sender keeps offering bytes, so the
    // block's registers fill and it must stall its input.
    initial begin : receiver
        int unsigned gap;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 99) < 8) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(30, 100)) @(posedge clk);
            end else begin
                gap = pick_gap();
                if (gap != 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // Offers one item and returns at the edge where the block takes it. The
    // sender sometimes runs a burst with no gaps. Valid stays high from one
    // item to the next when there is no gap, and the payload is held while
    // the block stalls.
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        if (burst_left != 0) begin
            burst_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 4) burst_left = $urandom_range(20, 80);
            gap = pick_gap();
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_block();
        foreach (blk[i]) send_item(blk[i]);
    endtask

    // Stops sending and waits until every predicted result has been taken,
    // then lets bytes that yield no result leave the pipeline.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_limit(input logic [7:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic put(input logic [7:0] b);
        blk.push_back('{rx_byte: b, block_start: 1'b0, block_end: 1'b0});
    endtask

    task automatic close_block(input bit first_start, input bit final_end);
        blk[0].block_start = first_start;
        blk[blk.size() - 1].block_end = final_end;
    endtask

    // Appends a well-formed information frame: optional ready byte, some
    // leading junk and extra zeros (overlapping preamble), the preamble,
    // length, length checksum, identifier, payload, checksum, postamble.
    task automatic build_frame(output int ident_at);
        int unsigned len;
        int unsigned r;
        if ($urandom_range(0, 9) < 7) put(READY_BYTE);
        repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) put(ZERO_BYTE);
        put(ZERO_BYTE);
        put(ZERO_BYTE);
        put(FF_BYTE);
        r = $urandom_range(0, 99);
        // Most frames are short; a few are long enough to run past the smaller limits.
        if (force_long) len = 255;
        else if (r < 70) len = $urandom_range(1, 12);
        else if (r < 90) len = $urandom_range(13, 40);
        else if (r < 98) len = $urandom_range(41, 120);
        else len = $urandom_range(200, 255);
        force_long = 1'b0;
        put(8'(len));
        put(($urandom_range(0, 9) < 8) ? 8'(256 - len) : 8'($urandom_range(0, 255)));
        ident_at = blk.size();
        put(RESP_ID);
        repeat (len - 1) put(8'($urandom_range(0, 255)));
        put(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) < 6) put(ZERO_BYTE);
    endtask

    // One random read block. Half are clean frames with random content; the
    // rest are acknowledges, truncated frames, bad identifiers, bad
    // acknowledge lengths, noise and frames with one corrupted byte.
    task automatic make_block();
        int          ident_at;
        int unsigned r;
        int unsigned cut;
        blk.delete();
        r = $urandom_range(0, 99);
        if (r < 50) begin
            build_frame(ident_at);
        end else if (r < 62) begin
            if ($urandom_range(0, 1)) put(READY_BYTE);
            put(ZERO_BYTE);
            put(ZERO_BYTE);
            put(FF_BYTE);
            put(ZERO_BYTE);
            put(FF_BYTE);
            put(ZERO_BYTE);
            // Bytes after an acknowledge are ignored up to the next block head.
            repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
        end else if (r < 70) begin
            build_frame(ident_at);
            cut = $urandom_range(1, blk.size());
            while (blk.size() > cut) void'(blk.pop_back());
        end else if (r < 77) begin
            build_frame(ident_at);
            blk[ident_at].rx_byte = RESP_ID ^ 8'($urandom_range(1, 255));
        end else if (r < 83) begin
            if ($urandom_range(0, 1)) put(READY_BYTE);
            put(ZERO_BYTE);
            put(ZERO_BYTE);
            put(FF_BYTE);
            put(ZERO_BYTE);
            if ($urandom_range(0, 1)) begin
                put(FF_BYTE ^ 8'($urandom_range(1, 255)));
            end else begin
                put(FF_BYTE);
                put(8'($urandom_range(1, 255)));
            end
            repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
        end else if (r < 92) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 4))
                    0: put(ZERO_BYTE);
                    1: put(FF_BYTE);
                    2: put(READY_BYTE);
                    3: put(RESP_ID);
                    default: put(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            build_frame(ident_at);
            blk[$urandom_range(0, blk.size() - 1)].rx_byte = 8'($urandom_range(0, 255));
        end
        // Most blocks open with the start flag and close with the end flag;
        // the others lean on the previous block's end or run into the next.
        close_block($urandom_range(0, 4) != 0, $urandom_range(0, 9) != 0);
    endtask

    initial begin : stimulus
        int unsigned sent;
        logic [7:0]  limit_plan [PHASES];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed blocks with the limit at its reset value.
        // Ready byte skipped, overlapping preamble, payload bytes 00 and FF,
        // and success on the checksum byte that also ends the block.
        blk.delete();
        put(READY_BYTE);
        put(ZERO_BYTE);
        put(ZERO_BYTE);
        put(ZERO_BYTE);
        put(FF_BYTE);
        put(8'h03);
        put(8'hFC);
        put(RESP_ID);
        put(ZERO_BYTE);
        put(FF_BYTE);
        put(8'h2E);
        close_block(1'b1, 1'b1);
        send_block();

        // Acknowledge completed on the last byte of its block.
        blk.delete();
        put(ZERO_BYTE);
        put(ZERO_BYTE);
        put(FF_BYTE);
        put(ZERO_BYTE);
        put(FF_BYTE);
        put(ZERO_BYTE);
        close_block(1'b1, 1'b1);
        send_block();

        // Zero length not followed by FF; the block head comes from the
        // previous block's end flag rather than a start flag.
        blk.delete();
        put(ZERO_BYTE);
        put(ZERO_BYTE);
        put(FF_BYTE);
        put(ZERO_BYTE);
        put(8'h12);
        close_block(1'b0, 1'b1);
        send_block();

        // The block ends on what would be a payload byte: failure, and the
        // byte is not delivered.
        blk.delete();
        put(ZERO_BYTE);
        put(ZERO_BYTE);
        put(FF_BYTE);
        put(8'h04);
        put(8'hFC);
        put(RESP_ID);
        put(8'h5A);
        close_block(1'b1, 1'b1);
        send_block();

        // Random phases, each under its own payload limit, extremes included.
        limit_plan = '{8'd0, 8'd255, 8'd1, 8'd3, 8'($urandom_range(0, 255)),
                       8'd128, 8'd2, 8'($urandom_range(4, 20))};
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_limit(limit_plan[p]);
            if (p < 2) force_long = 1'b1;
            if (p == 2) hold_req = 1'b1;
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                make_block();
                send_block();
                sent += blk.size();
            end
        end
        drain();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/nrd_pkg.sv
src/nrd_in_reg.sv
src/nrd_parser.sv
src/nrd_out_reg.sv
src/nfc_response_deframer_with_ack.sv
src/nrd_checker.sv
tb/deframer_checker.sv
tb/tb.sv
